// ----- rtl/phte_pkg.sv -----
// Shared types and constants of the profile HMM transition estimator.
// Holds the command, status, state kind and controller state codes.
// No dependencies; phte_datapath, phte_ctrl and the top module import it.
`default_nettype none

package phte_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_BUILD = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PHASE = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        K_BEGIN  = 2'd0,
        K_MATCH  = 2'd1,
        K_INSERT = 2'd2,
        K_DELETE = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD_DIV,
        S_LOAD_GAP_RD,
        S_LOAD_GAP_WR,
        S_B_GAP_RD,
        S_B_GAP_CHK,
        S_B_SYM_RD,
        S_B_SYM_CHK,
        S_B_TRANS_WR,
        S_B_END_RD,
        S_B_END_WR,
        S_R_SUM,
        S_R_DIV_GO,
        S_R_DIV_WAIT,
        S_EMIT
    } state_t;

    localparam logic [1:0] REG_NUM_ROWS      = 2'd0;
    localparam logic [1:0] REG_NUM_COLUMNS   = 2'd1;
    localparam logic [1:0] REG_GAP_THRESHOLD = 2'd2;

    localparam logic [1:0] SYM_OTHER  = 2'd0;
    localparam logic [1:0] SYM_NUCLEO = 2'd1;
    localparam logic [1:0] SYM_GAP    = 2'd2;

    localparam logic [1:0] SLOT_END = 2'd3;

    localparam logic [7:0] CH_GAP = 8'h5F;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_T   = 8'h54;
    localparam logic [7:0] CH_G   = 8'h47;
    localparam logic [7:0] CH_C   = 8'h43;

    localparam logic [6:0] RESET_NUM_ROWS      = 7'd64;
    localparam logic [6:0] RESET_NUM_COLUMNS   = 7'd64;
    localparam logic [6:0] RESET_GAP_THRESHOLD = 7'd2;

    localparam int PROB_BITS = 17;
    localparam int PROB_ONE  = 65536;

    typedef struct packed {
        logic    latch;
        logic    clear;
        logic    div_start_load;
        logic    col_take;
        logic    sym_wr;
        logic    gap_rd_load;
        logic    gap_wr_load;
        logic    bld_init;
        logic    gap_rd_bld;
        logic    gap_chk;
        logic    walk_init;
        logic    sym_rd;
        logic    trans_rd;
        logic    trans_wr;
        logic    col_adv;
        logic    end_rd;
        logic    end_wr;
        logic    row_adv;
        logic    set_built;
        logic    rd_cnt;
        logic    rd_sum;
        logic    div_start_prob;
        logic    div_take;
        logic    emit;
        logic    emit_full;
        status_t emit_status;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t    cmd;
        logic    load_ok;
        logic    col_ok;
        logic    build_ok;
        status_t read_status;
        logic    div_idle;
        logic    col_last;
        logic    row_last;
        logic    skip;
        logic    total_zero;
        logic    prob_last;
        logic    out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/phte_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no reset of the contents.
// No dependencies.
`default_nettype none

module phte_ram #(
    parameter int W = 8,
    parameter int D = 64,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/phte_div.sv -----
// Restoring divider, one quotient bit per cycle, for the estimator.
// Gives quotient and remainder; the divisor must be non-zero.
// No dependencies.
`default_nettype none

module phte_div #(
    parameter int DW = 30,
    parameter int VW = 13
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               idle,
    output logic      [DW-1:0] quotient,
    output logic      [VW-1:0] remainder
);

    localparam int NW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = NW'(DW);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign idle      = !busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/phte_datapath.sv -----
// Datapath of the estimator: registers, symbol, gap and count memories, divider.
// Acts on commands from phte_ctrl and reports status back to it.
// Depends on phte_pkg, phte_ram and phte_div.
`default_nettype none

module phte_datapath #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64,
    parameter int COUNT_BITS  = 13
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire phte_pkg::ctrl_cmd_t  cmd,
    output phte_pkg::dp_stat_t        st,
    input  wire logic [1:0]           command,
    input  wire logic [7:0]           symbol,
    input  wire logic [1:0]           state_kind,
    input  wire logic [6:0]           state_index,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [6:0]           cfg_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                status,
    output logic [6:0]                stable_columns,
    output logic [12:0]               count_to_match,
    output logic [12:0]               count_to_insert,
    output logic [12:0]               count_to_delete,
    output logic [12:0]               count_to_end,
    output logic [12:0]               total_out,
    output logic [16:0]               prob_to_match,
    output logic [16:0]               prob_to_insert,
    output logic [16:0]               prob_to_delete,
    output logic [16:0]               prob_to_end
);

    import phte_pkg::*;

    localparam int CB   = COUNT_BITS;
    localparam int SD   = MAX_ROWS * MAX_COLUMNS;
    localparam int AW   = (SD > 1) ? $clog2(SD) : 1;
    localparam int PW   = $clog2(SD + 1);
    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int CW   = $clog2(MAX_COLUMNS + 1);
    localparam int RIW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int GW   = $clog2(MAX_ROWS + 1);
    localparam int CD   = 3 * MAX_COLUMNS + 2;
    localparam int CAW  = $clog2(CD);
    localparam int DW   = CB + PROB_BITS;
    localparam int VW   = (CB > CW) ? CB : CW;

    function automatic logic [CAW-1:0] count_addr(input kind_t k, input logic [31:0] i);
        logic [31:0] a;
        case (k)
            K_BEGIN:  a = 32'd0;
            K_MATCH:  a = 32'd1 + i;
            K_INSERT: a = 32'd1 + 32'(MAX_COLUMNS) + i;
            K_DELETE: a = 32'd2 + 32'(2 * MAX_COLUMNS) + i;
            default:  a = 32'd0;
        endcase
        return CAW'(a);
    endfunction

    // Configuration and latched item.
    logic [6:0] num_rows_reg, num_cols_reg, thr_reg;
    cmd_t       in_cmd_reg;
    logic [7:0] in_sym_reg;
    kind_t      in_kind_reg;
    logic [6:0] in_idx_reg;

    // Model state.
    logic                   built_reg;
    logic [PW-1:0]          load_pos_reg;
    logic [CIW-1:0]         load_col_reg;
    logic [CW-1:0]          col_base_reg;
    logic [MAX_COLUMNS-1:0] gap_valid_reg;
    logic [MAX_COLUMNS-1:0] unstable_reg;
    logic [CD-1:0]          cnt_valid_reg;
    logic [CW-1:0]          stable_reg;

    // Build walk.
    logic [CIW-1:0] c_reg;
    logic [AW-1:0]  pos_reg;
    logic [RIW-1:0] r_reg;
    kind_t          pk_reg, nk_reg;
    logic [CW-1:0]  pi_reg, step_reg;
    logic [CAW-1:0] src_reg;
    logic           cv_rd_reg, gv_rd_reg;

    // Read results.
    logic [CB-1:0]        cnt_reg [4];
    logic [CB-1:0]        total_reg;
    logic [PROB_BITS-1:0] prob_reg [4];
    logic [1:0]           pj_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [1:0]           o_status_reg;
    logic [6:0]           o_stable_reg;
    logic [12:0]          o_cnt_reg [4];
    logic [12:0]          o_total_reg;
    logic [PROB_BITS-1:0] o_prob_reg [4];

    logic [RW-1:0]  rows_eff;
    logic [CW-1:0]  cols_eff;
    logic [6:0]     rows_c, cols_c;
    logic [PW-1:0]  total_cells;
    logic [1:0]     sym_code;
    logic [1:0]     sym_rdata;
    logic [GW-1:0]  gap_rdata, gap_cur, gap_wdata;
    logic [CIW-1:0] gap_raddr;
    logic           gap_we, gap_re;
    logic [4*CB-1:0] cnt_rdata, cnt_base, cnt_wdata;
    logic [CAW-1:0] src_addr, rd_addr, cnt_raddr;
    logic           cnt_re, cnt_we;
    logic [1:0]     slot_sel;
    logic           nuc;
    kind_t          nk;
    logic           gap_unstable;
    logic [CB+1:0]  sum;
    logic           div_start, div_idle;
    logic [DW-1:0]  div_dividend, div_quot;
    logic [VW-1:0]  div_divisor, div_rem;
    logic [PROB_BITS-1:0] prob_new;
    logic           out_free;

    always_comb
    begin
        rows_c = (num_rows_reg == 7'd0) ? 7'd1 : num_rows_reg;
        cols_c = (num_cols_reg == 7'd0) ? 7'd1 : num_cols_reg;
        rows_eff = (32'(rows_c) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_c);
        cols_eff = (32'(cols_c) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(cols_c);
        total_cells = PW'(32'(rows_eff) * 32'(cols_eff));
    end

    always_comb
    begin
        if (in_sym_reg == CH_A || in_sym_reg == CH_T || in_sym_reg == CH_G
            || in_sym_reg == CH_C)
        begin
            sym_code = SYM_NUCLEO;
        end
        else if (in_sym_reg == CH_GAP)
        begin
            sym_code = SYM_GAP;
        end
        else
        begin
            sym_code = SYM_OTHER;
        end
    end

    assign nuc = (sym_rdata == SYM_NUCLEO);
    assign nk  = unstable_reg[c_reg] ? K_INSERT : (nuc ? K_MATCH : K_DELETE);
    assign src_addr = count_addr(pk_reg, 32'(pi_reg));
    assign rd_addr  = count_addr(in_kind_reg,
                                 (in_kind_reg == K_BEGIN) ? 32'd0 : 32'(in_idx_reg));

    assign gap_cur      = gv_rd_reg ? gap_rdata : '0;
    assign gap_unstable = 32'(gap_cur) > 32'(thr_reg);
    assign gap_raddr    = cmd.gap_rd_load ? load_col_reg : c_reg;
    assign gap_re       = cmd.gap_rd_load | cmd.gap_rd_bld;
    assign gap_we       = cmd.gap_wr_load && (sym_code == SYM_GAP)
                          && (32'(gap_cur) < MAX_ROWS);
    assign gap_wdata    = gap_cur + 1'b1;

    assign cnt_raddr = cmd.rd_cnt ? rd_addr : src_addr;
    assign cnt_re    = cmd.trans_rd | cmd.end_rd | cmd.rd_cnt;
    assign cnt_we    = cmd.trans_wr | cmd.end_wr;
    assign cnt_base  = cv_rd_reg ? cnt_rdata : '0;
    assign slot_sel  = cmd.trans_wr ? (2'(nk_reg) - 2'd1) : SLOT_END;

    always_comb
    begin
        logic [CB-1:0] s;
        for (int j = 0; j < 4; j++)
        begin
            s = cnt_base[j*CB +: CB];
            if (slot_sel == 2'(j) && s != {CB{1'b1}})
            begin
                s = s + 1'b1;
            end
            cnt_wdata[j*CB +: CB] = s;
        end
    end

    assign sum = {2'b00, cnt_base[0 +: CB]} + {2'b00, cnt_base[CB +: CB]}
               + {2'b00, cnt_base[2*CB +: CB]} + {2'b00, cnt_base[3*CB +: CB]};

    assign div_start    = cmd.div_start_load | cmd.div_start_prob;
    assign div_dividend = cmd.div_start_load ? DW'(load_pos_reg)
                        : DW'({cnt_reg[pj_reg], 16'h0000}) + DW'(total_reg >> 1);
    assign div_divisor  = cmd.div_start_load ? VW'(cols_eff) : VW'(total_reg);
    assign prob_new     = (div_quot > DW'(PROB_ONE)) ? PROB_BITS'(PROB_ONE)
                                                     : PROB_BITS'(div_quot);

    assign out_free = !out_valid_reg || out_ready;

    phte_ram #(.W(2), .D(SD)) u_sym_ram (
        .clk   (clk),
        .we    (cmd.sym_wr),
        .waddr (load_pos_reg[AW-1:0]),
        .wdata (sym_code),
        .re    (cmd.sym_rd),
        .raddr (pos_reg),
        .rdata (sym_rdata)
    );

    phte_ram #(.W(GW), .D(MAX_COLUMNS)) u_gap_ram (
        .clk   (clk),
        .we    (gap_we),
        .waddr (load_col_reg),
        .wdata (gap_wdata),
        .re    (gap_re),
        .raddr (gap_raddr),
        .rdata (gap_rdata)
    );

    phte_ram #(.W(4*CB), .D(CD)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (src_reg),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    phte_div #(.DW(DW), .VW(VW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .idle      (div_idle),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= RESET_NUM_ROWS;
            num_cols_reg  <= RESET_NUM_COLUMNS;
            thr_reg       <= RESET_GAP_THRESHOLD;
            built_reg     <= 1'b0;
            load_pos_reg  <= '0;
            load_col_reg  <= '0;
            col_base_reg  <= '0;
            gap_valid_reg <= '0;
            unstable_reg  <= '0;
            cnt_valid_reg <= '0;
            stable_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_NUM_ROWS:      num_rows_reg <= cfg_data;
                    REG_NUM_COLUMNS:   num_cols_reg <= cfg_data;
                    REG_GAP_THRESHOLD: thr_reg      <= cfg_data;
                    default:           ;
                endcase
            end
            if (cmd.clear)
            begin
                built_reg     <= 1'b0;
                load_pos_reg  <= '0;
                load_col_reg  <= '0;
                col_base_reg  <= '0;
                gap_valid_reg <= '0;
                unstable_reg  <= '0;
                cnt_valid_reg <= '0;
                stable_reg    <= '0;
            end
            if (cmd.col_take)
            begin
                load_col_reg <= CIW'(div_rem);
                col_base_reg <= cols_eff;
            end
            if (gap_we)
            begin
                gap_valid_reg[load_col_reg] <= 1'b1;
            end
            if (cmd.gap_wr_load)
            begin
                load_pos_reg <= load_pos_reg + 1'b1;
                col_base_reg <= cols_eff;
                if (32'(load_col_reg) == 32'(cols_eff) - 32'd1)
                begin
                    load_col_reg <= '0;
                end
                else
                begin
                    load_col_reg <= load_col_reg + 1'b1;
                end
            end
            if (cmd.bld_init)
            begin
                stable_reg <= '0;
            end
            if (cmd.gap_chk)
            begin
                unstable_reg[c_reg] <= gap_unstable;
                if (!gap_unstable)
                begin
                    stable_reg <= stable_reg + 1'b1;
                end
            end
            if (cnt_we)
            begin
                cnt_valid_reg[src_reg] <= 1'b1;
            end
            if (cmd.set_built)
            begin
                built_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            in_cmd_reg  <= cmd_t'(command);
            in_sym_reg  <= symbol;
            in_kind_reg <= kind_t'(state_kind);
            in_idx_reg  <= state_index;
        end
        if (cmd.gap_rd_load)
        begin
            gv_rd_reg <= gap_valid_reg[load_col_reg];
        end
        if (cmd.gap_rd_bld)
        begin
            gv_rd_reg <= gap_valid_reg[c_reg];
        end
        if (cmd.bld_init || cmd.walk_init)
        begin
            c_reg <= '0;
        end
        if (cmd.gap_chk || cmd.col_adv)
        begin
            c_reg <= st.col_last ? '0 : c_reg + 1'b1;
        end
        if (cmd.walk_init)
        begin
            pos_reg <= '0;
            r_reg   <= '0;
        end
        if (cmd.col_adv)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.walk_init || cmd.row_adv)
        begin
            pk_reg   <= K_BEGIN;
            pi_reg   <= '0;
            step_reg <= '0;
        end
        if (cmd.row_adv)
        begin
            r_reg <= r_reg + 1'b1;
        end
        if (cmd.trans_rd)
        begin
            nk_reg <= nk;
        end
        if (cmd.trans_rd || cmd.end_rd)
        begin
            src_reg   <= src_addr;
            cv_rd_reg <= cnt_valid_reg[src_addr];
        end
        if (cmd.rd_cnt)
        begin
            cv_rd_reg <= cnt_valid_reg[rd_addr];
        end
        if (cmd.trans_wr)
        begin
            pk_reg <= nk_reg;
            pi_reg <= step_reg;
            if (nk_reg != K_INSERT)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
        if (cmd.rd_sum)
        begin
            for (int j = 0; j < 4; j++)
            begin
                cnt_reg[j]  <= cnt_base[j*CB +: CB];
                prob_reg[j] <= '0;
            end
            total_reg <= (sum > (CB+2)'({CB{1'b1}})) ? {CB{1'b1}} : CB'(sum);
            pj_reg    <= '0;
        end
        if (cmd.div_take)
        begin
            prob_reg[pj_reg] <= prob_new;
            pj_reg           <= pj_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            o_status_reg <= cmd.emit_status;
            o_stable_reg <= 7'(stable_reg);
            for (int j = 0; j < 4; j++)
            begin
                o_cnt_reg[j]  <= cmd.emit_full ? 13'({{13{1'b0}}, cnt_reg[j]}) : 13'd0;
                o_prob_reg[j] <= cmd.emit_full ? prob_reg[j] : '0;
            end
            o_total_reg <= cmd.emit_full ? 13'({{13{1'b0}}, total_reg}) : 13'd0;
        end
    end

    always_comb
    begin
        st.cmd        = in_cmd_reg;
        st.load_ok    = !built_reg && (load_pos_reg < total_cells);
        st.col_ok     = (col_base_reg == cols_eff) || (load_pos_reg == '0);
        st.build_ok   = !built_reg && (load_pos_reg == total_cells);
        if (!built_reg)
        begin
            st.read_status = ST_PHASE;
        end
        else if (((in_kind_reg == K_MATCH || in_kind_reg == K_DELETE)
                  && 32'(in_idx_reg) >= 32'(stable_reg))
                 || (in_kind_reg == K_INSERT && 32'(in_idx_reg) > 32'(stable_reg)))
        begin
            st.read_status = ST_RANGE;
        end
        else
        begin
            st.read_status = ST_OK;
        end
        st.div_idle   = div_idle;
        st.col_last   = (32'(c_reg) == 32'(cols_eff) - 32'd1);
        st.row_last   = (32'(r_reg) == 32'(rows_eff) - 32'd1);
        st.skip       = unstable_reg[c_reg] && !nuc;
        st.total_zero = (total_reg == '0);
        st.prob_last  = (pj_reg == 2'd3);
        st.out_free   = out_free;
    end

    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign status          = o_status_reg;
    assign stable_columns  = o_stable_reg;
    assign count_to_match  = o_cnt_reg[0];
    assign count_to_insert = o_cnt_reg[1];
    assign count_to_delete = o_cnt_reg[2];
    assign count_to_end    = o_cnt_reg[3];
    assign total_out       = o_total_reg;
    assign prob_to_match   = o_prob_reg[0];
    assign prob_to_insert  = o_prob_reg[1];
    assign prob_to_delete  = o_prob_reg[2];
    assign prob_to_end     = o_prob_reg[3];

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("Result beat written while the output register is full.");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> div_idle)
        else $error("Divider started while busy.");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (!built_reg && load_pos_reg == '0 && stable_reg == '0))
        else $error("Clear did not return the model to loading.");

    a_no_wr_race: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> !cnt_re)
        else $error("Count memory read and written in the same cycle.");

endmodule

`default_nettype wire

// ----- rtl/phte_ctrl.sv -----
// Controller state machine of the estimator.
// Sequences load, build and read work through command and status structs.
// Depends on phte_pkg.
`default_nettype none

module phte_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire phte_pkg::dp_stat_t  st,
    output phte_pkg::ctrl_cmd_t      cmd
);

    import phte_pkg::*;

    state_t  state_reg, state_next;
    status_t est_reg, est_next;
    logic    efull_reg, efull_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            est_reg   <= ST_OK;
            efull_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            est_reg   <= est_next;
            efull_reg <= efull_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        est_next   = est_reg;
        efull_next = efull_reg;
        cmd        = '0;
        cmd.emit_status = est_reg;
        cmd.emit_full   = efull_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                est_next   = ST_OK;
                efull_next = 1'b0;
                case (st.cmd)
                    CMD_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_EMIT;
                    end
                    CMD_LOAD:
                    begin
                        if (!st.load_ok)
                        begin
                            est_next   = ST_PHASE;
                            state_next = S_EMIT;
                        end
                        else if (st.col_ok)
                        begin
                            state_next = S_LOAD_GAP_RD;
                        end
                        else
                        begin
                            cmd.div_start_load = 1'b1;
                            state_next         = S_LOAD_DIV;
                        end
                    end
                    CMD_BUILD:
                    begin
                        if (!st.build_ok)
                        begin
                            est_next   = ST_PHASE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.bld_init = 1'b1;
                            state_next   = S_B_GAP_RD;
                        end
                    end
                    default:
                    begin
                        if (st.read_status != ST_OK)
                        begin
                            est_next   = st.read_status;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.rd_cnt = 1'b1;
                            state_next = S_R_SUM;
                        end
                    end
                endcase
            end
            S_LOAD_DIV:
            begin
                if (st.div_idle)
                begin
                    cmd.col_take = 1'b1;
                    state_next   = S_LOAD_GAP_RD;
                end
            end
            S_LOAD_GAP_RD:
            begin
                cmd.sym_wr      = 1'b1;
                cmd.gap_rd_load = 1'b1;
                state_next      = S_LOAD_GAP_WR;
            end
            S_LOAD_GAP_WR:
            begin
                cmd.gap_wr_load = 1'b1;
                state_next      = S_EMIT;
            end
            S_B_GAP_RD:
            begin
                cmd.gap_rd_bld = 1'b1;
                state_next     = S_B_GAP_CHK;
            end
            S_B_GAP_CHK:
            begin
                cmd.gap_chk = 1'b1;
                if (st.col_last)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_B_SYM_RD;
                end
                else
                begin
                    state_next = S_B_GAP_RD;
                end
            end
            S_B_SYM_RD:
            begin
                cmd.sym_rd = 1'b1;
                state_next = S_B_SYM_CHK;
            end
            S_B_SYM_CHK:
            begin
                if (st.skip)
                begin
                    cmd.col_adv = 1'b1;
                    state_next  = st.col_last ? S_B_END_RD : S_B_SYM_RD;
                end
                else
                begin
                    cmd.trans_rd = 1'b1;
                    state_next   = S_B_TRANS_WR;
                end
            end
            S_B_TRANS_WR:
            begin
                cmd.trans_wr = 1'b1;
                cmd.col_adv  = 1'b1;
                state_next   = st.col_last ? S_B_END_RD : S_B_SYM_RD;
            end
            S_B_END_RD:
            begin
                cmd.end_rd = 1'b1;
                state_next = S_B_END_WR;
            end
            S_B_END_WR:
            begin
                cmd.end_wr  = 1'b1;
                cmd.row_adv = 1'b1;
                if (st.row_last)
                begin
                    cmd.set_built = 1'b1;
                    state_next    = S_EMIT;
                end
                else
                begin
                    state_next = S_B_SYM_RD;
                end
            end
            S_R_SUM:
            begin
                cmd.rd_sum = 1'b1;
                efull_next = 1'b1;
                state_next = S_R_DIV_GO;
            end
            S_R_DIV_GO:
            begin
                if (st.total_zero)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.div_start_prob = 1'b1;
                    state_next         = S_R_DIV_WAIT;
                end
            end
            S_R_DIV_WAIT:
            begin
                if (st.div_idle)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = st.prob_last ? S_EMIT : S_R_DIV_GO;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/profile_hmm_transition_estimator_top.sv -----
// Profile HMM transition estimator: an alignment is loaded symbol by symbol, a
// build command walks every row and counts state transitions, and a read command
// returns one state's counts and Q1.16 probabilities. One command is worked at a
// time and each gives one result beat. A load finds the column with the shared
// bit-serial divider when num_columns changed since the last load. A read makes
// four divisions, or none when the total is zero.
// A new command is taken while the previous result beat still waits.
// Depends on phte_pkg, phte_ctrl, phte_datapath, phte_ram and phte_div.
`default_nettype none

module profile_hmm_transition_estimator_top #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 64,
    parameter int COUNT_BITS  = 13
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // symbol [7:0], state_kind [9:8], state_index [16:10], zero [23:17].
    input  wire logic [23:0]  s_tdata,
    // command [1:0].
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // stable_columns [6:0], count_to_match [19:7], count_to_insert [32:20],
    // count_to_delete [45:33], count_to_end [58:46], total_out [71:59],
    // prob_to_match [88:72], prob_to_insert [105:89], prob_to_delete [122:106],
    // prob_to_end [139:123], zero [143:140].
    output logic [143:0]      m_tdata,
    // status [1:0].
    output logic [1:0]        m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [6:0]   cfg_data
);

    import phte_pkg::*;

    ctrl_cmd_t   cmd;
    dp_stat_t    st;
    logic [6:0]  stable_columns;
    logic [12:0] c_m, c_i, c_d, c_e, total;
    logic [16:0] p_m, p_i, p_d, p_e;

    phte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    phte_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .command         (s_tuser),
        .symbol          (s_tdata[7:0]),
        .state_kind      (s_tdata[9:8]),
        .state_index     (s_tdata[16:10]),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .status          (m_tuser),
        .stable_columns  (stable_columns),
        .count_to_match  (c_m),
        .count_to_insert (c_i),
        .count_to_delete (c_d),
        .count_to_end    (c_e),
        .total_out       (total),
        .prob_to_match   (p_m),
        .prob_to_insert  (p_i),
        .prob_to_delete  (p_d),
        .prob_to_end     (p_e)
    );

    assign m_tdata = {4'h0, p_e, p_d, p_i, p_m, total, c_e, c_d, c_i, c_m, stable_columns};

endmodule

`default_nettype wire
